// File: hw/rtl/msdt_pkg.sv
// Shared types and codes for the multi-slot deadline timer.
// Used by msdt_ctrl, msdt_dp and the top level.
`timescale 1ns / 1ps
package msdt_pkg;

    localparam logic [2:0] K_CREATE = 3'd0;
    localparam logic [2:0] K_DELETE = 3'd1;
    localparam logic [2:0] K_REARM  = 3'd2;
    localparam logic [2:0] K_POLL   = 3'd3;
    localparam logic [2:0] K_QUERY  = 3'd4;

    localparam logic [2:0] W_DONE    = 3'd0;
    localparam logic [2:0] W_FIRED   = 3'd1;
    localparam logic [2:0] W_SUMMARY = 3'd2;
    localparam logic [2:0] W_SLEEP   = 3'd3;
    localparam logic [2:0] W_ERROR   = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_WALK  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk_step;
        logic scan_start;
        logic scan_step;
        logic fin;
        logic emit_fire;
        logic emit_final;
    } cmd_t;

    typedef struct packed {
        logic is_poll;
        logic is_delete;
        logic walk_done;
        logic walk_fire;
        logic scan_done;
    } sts_t;

endpackage

// File: hw/rtl/msdt_ctrl.sv
// Sequencer for the timer table: steps through decode, slot walk and scan.
// Depends on msdt_pkg.
`timescale 1ns / 1ps
module msdt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  out_busy,
    input  msdt_pkg::sts_t        sts,
    output msdt_pkg::cmd_t        cmd
);
    msdt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msdt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != msdt_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            msdt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = msdt_pkg::S_EXEC;
                end
            end
            msdt_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.is_poll)
                begin
                    state_next = msdt_pkg::S_WALK;
                end
                else if (sts.is_delete)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = msdt_pkg::S_SCAN;
                end
                else
                begin
                    state_next = msdt_pkg::S_FIN;
                end
            end
            msdt_pkg::S_WALK:
            begin
                if (!(sts.walk_fire && out_busy))
                begin
                    cmd.walk_step = 1'b1;
                    cmd.emit_fire = sts.walk_fire;
                    if (sts.walk_done)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = msdt_pkg::S_SCAN;
                    end
                end
            end
            msdt_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = msdt_pkg::S_FIN;
                end
            end
            msdt_pkg::S_FIN:
            begin
                cmd.fin = 1'b1;
                state_next = msdt_pkg::S_OUT;
            end
            msdt_pkg::S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.emit_final = 1'b1;
                    state_next = msdt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = msdt_pkg::S_IDLE;
            end
        endcase
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != msdt_pkg::S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msdt_pkg::S_FIN) |=> (state_reg == msdt_pkg::S_OUT))
        else $error("finish not followed by output");
endmodule

// File: hw/rtl/msdt_dp.sv
// Datapath: slot table, time registers, walk and minimum scan, output register.
// Depends on msdt_pkg.
`timescale 1ns / 1ps
module msdt_dp #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  msdt_pkg::cmd_t        cmd,
    output msdt_pkg::sts_t        sts,
    input  logic [2:0]            kind,
    input  logic [3:0]            slot,
    input  logic [TIME_BITS-1:0]  interval,
    input  logic                  periodic,
    input  logic [TIME_BITS-1:0]  delay,
    input  logic [TIME_BITS-1:0]  now,
    input  logic                  force_req,
    input  logic [TIME_BITS-1:0]  default_sleep,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            what,
    output logic [3:0]            slot_res,
    output logic [TIME_BITS-1:0]  earliest,
    output logic [TIME_BITS-1:0]  sleep_ms,
    output logic                  last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
    localparam logic [IW:0] NSLOTS = (IW+1)'(SLOTS);

    logic [SLOTS-1:0]     active_reg, repeats_reg;
    logic [TIME_BITS-1:0] period_mem [SLOTS];
    logic [TIME_BITS-1:0] dl_mem [SLOTS];
    logic [TIME_BITS-1:0] seen_reg, soon_reg, min_reg;

    logic [2:0]           k_reg;
    logic [3:0]           s_reg;
    logic [TIME_BITS-1:0] iv_reg, dly_reg, now_reg, dflt_reg;
    logic                 per_reg, frc_reg;
    logic [IW:0]          idx_reg;
    logic [2:0]           res_what_reg;
    logic [3:0]           res_slot_reg;
    logic [TIME_BITS-1:0] res_earl_reg, res_sleep_reg;

    logic                 free_found;
    logic [IW-1:0]        free_idx;
    logic                 slot_ok;
    logic [IW-1:0]        sidx, widx;
    logic                 due;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
    endfunction

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign sidx = IW'(s_reg);
    assign slot_ok = ({1'b0, s_reg} < 5'(SLOTS)) && active_reg[sidx];
    assign widx = idx_reg[IW-1:0] - IW'(1);
    assign due = active_reg[widx]
                 && (frc_reg || (dl_mem[widx] <= now_reg));

    assign sts.is_poll = (k_reg == msdt_pkg::K_POLL);
    assign sts.is_delete = (k_reg == msdt_pkg::K_DELETE) && slot_ok;
    assign sts.walk_done = (idx_reg == (IW+1)'(1));
    assign sts.walk_fire = due;
    assign sts.scan_done = (idx_reg == NSLOTS - (IW+1)'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            repeats_reg <= '0;
            seen_reg <= '0;
            soon_reg <= TMAX;
            out_valid <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (cmd.load)
            begin
                k_reg <= kind;
                s_reg <= slot;
                iv_reg <= interval;
                dly_reg <= delay;
                now_reg <= now;
                dflt_reg <= default_sleep;
                per_reg <= periodic;
                frc_reg <= force_req;
            end
            if (cmd.exec)
            begin
                res_slot_reg <= s_reg;
                res_what_reg <= msdt_pkg::W_ERROR;
                idx_reg <= NSLOTS;
                case (k_reg)
                    msdt_pkg::K_CREATE:
                    begin
                        res_slot_reg <= 4'(free_idx);
                        if (free_found)
                        begin
                            active_reg[free_idx] <= 1'b1;
                            repeats_reg[free_idx] <= per_reg;
                            period_mem[free_idx] <= iv_reg;
                            dl_mem[free_idx] <= sat_add(now_reg, iv_reg);
                            seen_reg <= now_reg;
                            res_what_reg <= msdt_pkg::W_DONE;
                        end
                        else
                        begin
                            res_slot_reg <= '0;
                        end
                    end
                    msdt_pkg::K_DELETE:
                    begin
                        if (slot_ok)
                        begin
                            active_reg[sidx] <= 1'b0;
                            repeats_reg[sidx] <= 1'b0;
                            res_what_reg <= msdt_pkg::W_DONE;
                        end
                    end
                    msdt_pkg::K_REARM:
                    begin
                        if (slot_ok)
                        begin
                            dl_mem[sidx] <= sat_add(seen_reg,
                                (dly_reg != '0) ? dly_reg : period_mem[sidx]);
                            res_what_reg <= msdt_pkg::W_DONE;
                        end
                    end
                    msdt_pkg::K_POLL:
                    begin
                        seen_reg <= now_reg;
                        res_what_reg <= msdt_pkg::W_SUMMARY;
                        res_slot_reg <= '0;
                    end
                    msdt_pkg::K_QUERY:
                    begin
                        seen_reg <= now_reg;
                        res_what_reg <= msdt_pkg::W_SLEEP;
                        res_slot_reg <= '0;
                    end
                    default:
                    begin
                        res_what_reg <= msdt_pkg::W_ERROR;
                    end
                endcase
            end
            if (cmd.walk_step)
            begin
                idx_reg <= idx_reg - (IW+1)'(1);
                if (due)
                begin
                    dl_mem[widx] <= sat_add(now_reg, period_mem[widx]);
                    if (!repeats_reg[widx])
                    begin
                        active_reg[widx] <= 1'b0;
                    end
                end
            end
            if (cmd.emit_fire)
            begin
                out_valid <= 1'b1;
                what <= msdt_pkg::W_FIRED;
                slot_res <= 4'(widx);
                earliest <= '0;
                sleep_ms <= '0;
                last <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
                min_reg <= TMAX;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + (IW+1)'(1);
                if (active_reg[idx_reg[IW-1:0]] && (dl_mem[idx_reg[IW-1:0]] < min_reg))
                begin
                    min_reg <= dl_mem[idx_reg[IW-1:0]];
                end
                if (sts.scan_done)
                begin
                    soon_reg <= (active_reg[idx_reg[IW-1:0]]
                                 && (dl_mem[idx_reg[IW-1:0]] < min_reg))
                                ? dl_mem[idx_reg[IW-1:0]] : min_reg;
                end
            end
            if (cmd.fin)
            begin
                res_earl_reg <= soon_reg;
                if (active_reg == '0)
                begin
                    res_sleep_reg <= dflt_reg;
                end
                else if (soon_reg > now_reg)
                begin
                    res_sleep_reg <= soon_reg - now_reg;
                end
                else
                begin
                    res_sleep_reg <= '0;
                end
            end
            if (cmd.emit_final)
            begin
                out_valid <= 1'b1;
                what <= res_what_reg;
                slot_res <= res_slot_reg;
                earliest <= res_earl_reg;
                if (res_what_reg == msdt_pkg::W_SUMMARY || res_what_reg == msdt_pkg::W_SLEEP)
                begin
                    sleep_ms <= res_sleep_reg;
                end
                else
                begin
                    sleep_ms <= '0;
                end
                last <= 1'b1;
            end
        end
    end

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && what == msdt_pkg::W_FIRED) |-> !last)
        else $error("fired word marked last");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_fire || cmd.emit_final) |-> (!out_valid || !out_stall) == 1'b1 || !out_valid)
        else $error("output overwritten");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(cmd.walk_step || cmd.scan_step))
        else $error("load during walk");
endmodule

// File: hw/rtl/multi_slot_deadline_timer.sv
// Top level of the multi-slot deadline timer table.
// Depends on msdt_pkg, msdt_ctrl and msdt_dp.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one command word: create,
//   delete, rearm, poll or sleep query. Output channel (out_valid /
//   out_stall) returns result words; the final word of a command has last=1.
//   One command at a time: in_stall is high from acceptance until its final
//   word is loaded into the output register.
//   Create, rearm, query and bad commands: the result word is loaded once the
//   output register is free; the next command is taken in the cycle after that.
//   Delete of an active slot: minimum scan over the table before the result word.
//   Poll: one slot walked per cycle (highest first), pausing while a fired
//   slot waits for the output register, then one slot scanned per cycle;
//   each fired slot emits a word. Throughput is set by the sequencer.
//   A stalled receiver holds the output word; the walk pauses on a firing
//   slot until the register is free.
//   Reset clears all slots, the last seen time and the earliest deadline
//   (all ones); period and deadline storage stays unset until written.
`timescale 1ns / 1ps
module multi_slot_deadline_timer #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            kind,
    input  logic [3:0]            slot,
    input  logic [TIME_BITS-1:0]  interval,
    input  logic                  periodic,
    input  logic [TIME_BITS-1:0]  delay,
    input  logic [TIME_BITS-1:0]  now,
    input  logic                  force_req,
    input  logic [TIME_BITS-1:0]  default_sleep,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            what,
    output logic [3:0]            slot_res,
    output logic [TIME_BITS-1:0]  earliest,
    output logic [TIME_BITS-1:0]  sleep_ms,
    output logic                  last
);
    msdt_pkg::cmd_t cmd;
    msdt_pkg::sts_t sts;
    logic           out_busy;

    assign out_busy = out_valid && out_stall;

    msdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    msdt_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .slot          (slot),
        .interval      (interval),
        .periodic      (periodic),
        .delay         (delay),
        .now           (now),
        .force_req     (force_req),
        .default_sleep (default_sleep),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .what          (what),
        .slot_res      (slot_res),
        .earliest      (earliest),
        .sleep_ms      (sleep_ms),
        .last          (last)
    );
endmodule

// File: tb/timer_table_checker.sv
// Checker for the multi-slot deadline timer: watches both channels, keeps its own
// copy of the timer table, predicts result words and compares them in order.
// Depends on msdt_pkg.
`timescale 1ns / 1ps
module timer_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [3:0]  slot,
    input  logic [47:0] interval,
    input  logic        periodic,
    input  logic [47:0] delay,
    input  logic [47:0] now,
    input  logic        force_req,
    input  logic [47:0] default_sleep,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  what,
    input  logic [3:0]  slot_res,
    input  logic [47:0] earliest,
    input  logic [47:0] sleep_ms,
    input  logic        last,
    output int          fail_count,
    output int          pending
);
    localparam logic [47:0] TMAX = '1;

    typedef struct packed {
        logic [2:0]  what;
        logic [3:0]  slot;
        logic [47:0] earliest;
        logic [47:0] sleep;
        logic        last;
    } result_t;

    result_t     result_q[$];
    logic        t_active[16];
    logic        t_repeat[16];
    logic [47:0] t_period[16];
    logic [47:0] t_deadline[16];
    logic [47:0] t_seen;
    logic [47:0] t_soonest;

    assign pending = result_q.size();

    function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TMAX : s[47:0];
    endfunction

    function automatic void refresh_soonest();
        t_soonest = TMAX;
        for (int i = 0; i < 16; i++)
            if (t_active[i] && t_deadline[i] < t_soonest)
                t_soonest = t_deadline[i];
    endfunction

    function automatic logic [47:0] sleep_for(logic [47:0] t, logic [47:0] dflt);
        logic any;
        any = 1'b0;
        for (int i = 0; i < 16; i++)
            any |= t_active[i];
        if (!any)
            return dflt;
        return (t_soonest > t) ? t_soonest - t : 48'd0;
    endfunction

    function automatic void push(logic [2:0] w, logic [3:0] s, logic [47:0] e,
                                 logic [47:0] sl, logic l);
        result_t r;
        r.what = w;
        r.slot = s;
        r.earliest = e;
        r.sleep = sl;
        r.last = l;
        result_q.push_back(r);
    endfunction

    function automatic void predict_word();
        int free_slot;
        free_slot = -1;
        case (kind)
            msdt_pkg::K_CREATE:
            begin
                for (int i = 15; i >= 0; i--)
                    if (!t_active[i])
                        free_slot = i;
                if (free_slot < 0)
                    push(msdt_pkg::W_ERROR, 4'd0, t_soonest, 48'd0, 1'b1);
                else
                begin
                    t_active[free_slot] = 1'b1;
                    t_repeat[free_slot] = periodic;
                    t_period[free_slot] = interval;
                    t_seen = now;
                    t_deadline[free_slot] = sat_sum(now, interval);
                    push(msdt_pkg::W_DONE, 4'(free_slot), t_soonest, 48'd0, 1'b1);
                end
            end
            msdt_pkg::K_DELETE:
            begin
                if (!t_active[slot])
                    push(msdt_pkg::W_ERROR, slot, t_soonest, 48'd0, 1'b1);
                else
                begin
                    t_active[slot] = 1'b0;
                    t_repeat[slot] = 1'b0;
                    refresh_soonest();
                    push(msdt_pkg::W_DONE, slot, t_soonest, 48'd0, 1'b1);
                end
            end
            msdt_pkg::K_REARM:
            begin
                if (!t_active[slot])
                    push(msdt_pkg::W_ERROR, slot, t_soonest, 48'd0, 1'b1);
                else
                begin
                    t_deadline[slot] = sat_sum(t_seen, delay != 0 ? delay : t_period[slot]);
                    push(msdt_pkg::W_DONE, slot, t_soonest, 48'd0, 1'b1);
                end
            end
            msdt_pkg::K_POLL:
            begin
                t_seen = now;
                for (int i = 15; i >= 0; i--)
                    if (t_active[i] && (t_deadline[i] <= now || force_req))
                    begin
                        t_deadline[i] = sat_sum(now, t_period[i]);
                        if (!t_repeat[i])
                            t_active[i] = 1'b0;
                        push(msdt_pkg::W_FIRED, 4'(i), 48'd0, 48'd0, 1'b0);
                    end
                refresh_soonest();
                push(msdt_pkg::W_SUMMARY, 4'd0, t_soonest,
                     sleep_for(now, default_sleep), 1'b1);
            end
            msdt_pkg::K_QUERY:
            begin
                t_seen = now;
                push(msdt_pkg::W_SLEEP, 4'd0, t_soonest,
                     sleep_for(now, default_sleep), 1'b1);
            end
            default:
                push(msdt_pkg::W_ERROR, slot, t_soonest, 48'd0, 1'b1);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t_active[i] = 1'b0;
                t_repeat[i] = 1'b0;
                t_period[i] = '0;
                t_deadline[i] = '0;
            end
            t_seen = '0;
            t_soonest = TMAX;
            result_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected word what=%0d slot=%0d", $time, what, slot_res);
                    fail_count++;
                end
                else
                begin
                    e = result_q.pop_front();
                    if ({what, slot_res, earliest, sleep_ms, last} != e)
                    begin
                        $display({"%0t: mismatch expected what=%0d slot=%0d ",
                                  "earliest=%h sleep=%h last=%0d"},
                                 $time, e.what, e.slot, e.earliest, e.sleep, e.last);
                        $display({"%0t:          actual what=%0d slot=%0d ",
                                  "earliest=%h sleep=%h last=%0d"},
                                 $time, what, slot_res, earliest, sleep_ms, last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_word();
        end
    end
endmodule

// File: tb/testbench.sv
// Testbench top for the multi-slot deadline timer: drives command words with
// random gaps and receiver stalls, and reports the verdict from the checker.
// Depends on msdt_pkg, multi_slot_deadline_timer and timer_table_checker.
`timescale 1ns / 1ps
module testbench;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [3:0]  slot = '0;
    logic [47:0] interval = '0;
    logic        periodic = 1'b0;
    logic [47:0] delay = '0;
    logic [47:0] now = '0;
    logic        force_req = 1'b0;
    logic [47:0] default_sleep = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  what;
    logic [3:0]  slot_res;
    logic [47:0] earliest;
    logic [47:0] sleep_ms;
    logic        last;
    int          fail_count;
    int          pending;
    logic        calm = 1'b0;
    logic [47:0] clock_ms = '0;

    always #2 clk = ~clk;

    multi_slot_deadline_timer dut (.*);

    timer_table_checker checker_i (.*);

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] rand_span();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return rand48();
            2: return '1;
            default: return 48'($urandom_range(1, 200));
        endcase
    endfunction

    task automatic send(logic [2:0] k, logic [3:0] s, logic [47:0] iv, logic p,
                        logic [47:0] d, logic [47:0] t, logic f, logic [47:0] ds);
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(negedge clk);
        kind <= k;
        slot <= s;
        interval <= iv;
        periodic <= p;
        delay <= d;
        now <= t;
        force_req <= f;
        default_sleep <= ds;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 40) == 0)
            clock_ms = rand48();
        else
            clock_ms = clock_ms + 48'($urandom_range(0, 60));
        if (r < 30)
            send(msdt_pkg::K_CREATE, 4'($urandom()), rand_span(), 1'($urandom()),
                 rand48(), clock_ms, 1'($urandom()), rand48());
        else if (r < 42)
            send(msdt_pkg::K_DELETE, 4'($urandom()), rand48(), 1'($urandom()),
                 rand48(), rand48(), 1'($urandom()), rand48());
        else if (r < 55)
            send(msdt_pkg::K_REARM, 4'($urandom()), rand48(), 1'($urandom()),
                 rand_span(), rand48(), 1'($urandom()), rand48());
        else if (r < 80)
            send(msdt_pkg::K_POLL, 4'($urandom()), rand48(), 1'($urandom()),
                 rand48(), clock_ms, $urandom_range(0, 7) == 0, rand48());
        else if (r < 95)
            send(msdt_pkg::K_QUERY, 4'($urandom()), rand48(), 1'($urandom()),
                 rand48(), clock_ms, 1'($urandom()), rand48());
        else
            send(3'($urandom_range(5, 7)), 4'($urandom()), rand48(), 1'($urandom()),
                 rand48(), rand48(), 1'($urandom()), rand48());
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send(msdt_pkg::K_QUERY, 4'd0, '0, 1'b0, '0, '0, 1'b0, '1);
        send(msdt_pkg::K_POLL, 4'd0, '0, 1'b0, '0, 48'd5, 1'b0, 48'd77);
        send(msdt_pkg::K_DELETE, 4'd15, '0, 1'b0, '0, '0, 1'b0, '0);
        send(msdt_pkg::K_REARM, 4'd3, '0, 1'b0, 48'd1, '0, 1'b0, '0);
        for (int i = 0; i < 16; i++)
            send(msdt_pkg::K_CREATE, 4'd0, (i == 0) ? '1 : 48'(i * 10), 1'(i), '0,
                 (i == 1) ? '1 : 48'd100, 1'b0, '0);
        send(msdt_pkg::K_CREATE, 4'd0, 48'd1, 1'b1, '0, 48'd100, 1'b0, '0);
        send(msdt_pkg::K_REARM, 4'd2, '0, 1'b0, '0, '0, 1'b0, '0);
        send(msdt_pkg::K_REARM, 4'd4, '0, 1'b0, '1, '0, 1'b0, '0);
        send(msdt_pkg::K_DELETE, 4'd5, '0, 1'b0, '0, '0, 1'b0, '0);
        send(msdt_pkg::K_QUERY, 4'd0, '0, 1'b0, '0, 48'd120, 1'b0, '0);
        send(msdt_pkg::K_POLL, 4'd0, '0, 1'b0, '0, 48'd150, 1'b0, '0);
        send(msdt_pkg::K_POLL, 4'd0, '0, 1'b0, '0, 48'd160, 1'b1, '0);
        send(3'd7, 4'd9, '1, 1'b1, '1, '1, 1'b1, '1);
        send(msdt_pkg::K_POLL, 4'd0, '0, 1'b0, '0, '1, 1'b1, '1);
        clock_ms = 48'd200;
        for (int n = 0; n < 410; n++)
        begin
            if (n == 200)
                wait (pending == 0);
            if (n == 340)
                calm = 1'b1;
            send_random();
        end
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/msdt_pkg.sv
hw/rtl/msdt_ctrl.sv
hw/rtl/msdt_dp.sv
hw/rtl/multi_slot_deadline_timer.sv
tb/timer_table_checker.sv
tb/testbench.sv
